// ===== design/smd_pkg.sv =====
// Package: SHA-1 digest unit types and constants.
package smd_pkg;
	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [6:0] LAST_ROUND = 7'd79;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_PAD,
		ST_FILL,
		ST_LEN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic put_byte;
		logic [7:0] put_val;
		logic count_inc;
		logic put_len;
		logic start;
		logic round;
		logic finish;
		logic reset_msg;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
		logic last_round;
	} dp_sts_t;
endpackage

// ===== design/smd_ctrl.sv =====
// Controller state machine for the SHA-1 digest unit.
module smd_ctrl import smd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic [7:0] in_byte,
	input logic in_has,
	input logic in_last,
	output logic in_rdy,
	input logic out_fire,
	output logic out_vld,
	output logic [2:0] out_idx,
	input dp_sts_t sts,
	output dp_cmd_t cmd
);
	state_t state_q, state_d;
	logic pend_last_q, pend_last_d;
	logic pad_done_q, pad_done_d;
	logic len_done_q, len_done_d;
	logic [2:0] idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_last_q <= 1'b0;
			pad_done_q <= 1'b0;
			len_done_q <= 1'b0;
			idx_q <= 3'd0;
		end else begin
			state_q <= state_d;
			pend_last_q <= pend_last_d;
			pad_done_q <= pad_done_d;
			len_done_q <= len_done_d;
			idx_q <= idx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pend_last_d = pend_last_q;
		pad_done_d = pad_done_q;
		len_done_d = len_done_q;
		idx_d = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					pend_last_d = in_last;
					pad_done_d = 1'b0;
					len_done_d = 1'b0;
					if (in_has && sts.pos == 6'd63) state_d = ST_COMP;
					else if (in_last) state_d = ST_PAD;
				end
			end
			ST_COMP: begin
				if (sts.last_round) begin
					if (!pend_last_q) state_d = ST_IDLE;
					else if (len_done_q) state_d = ST_EMIT;
					else if (pad_done_q) state_d = ST_FILL;
					else state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				pad_done_d = 1'b1;
				if (sts.pos == 6'd55) state_d = ST_LEN;
				else if (sts.pos == 6'd63) state_d = ST_COMP;
				else state_d = ST_FILL;
			end
			ST_FILL: begin
				if (sts.pos == 6'd55) state_d = ST_LEN;
				else if (sts.pos == 6'd63) state_d = ST_COMP;
			end
			ST_LEN: begin
				len_done_d = 1'b1;
				state_d = ST_COMP;
			end
			ST_EMIT: begin
				if (out_fire) begin
					if (idx_q == 3'd4) begin
						idx_d = 3'd0;
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_rdy = 1'b0;
		out_vld = 1'b0;
		out_idx = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				in_rdy = 1'b1;
				cmd.put_byte = in_fire && in_has;
				cmd.count_inc = in_fire && in_has;
				cmd.put_val = in_byte;
				cmd.start = in_fire && in_has && sts.pos == 6'd63;
			end
			ST_COMP: cmd.round = 1'b1;
			ST_PAD: begin
				cmd.put_val = PAD_MARK;
				cmd.put_byte = 1'b1;
				cmd.start = sts.pos == 6'd63;
			end
			ST_FILL: begin
				cmd.put_val = 8'h00;
				cmd.put_byte = 1'b1;
				cmd.start = sts.pos == 6'd63;
			end
			ST_LEN: begin
				cmd.put_len = 1'b1;
				cmd.start = 1'b1;
			end
			ST_EMIT: begin
				out_vld = 1'b1;
				cmd.reset_msg = out_fire && idx_q == 3'd4;
			end
			default: ;
		endcase
		cmd.finish = state_q == ST_COMP && sts.last_round;
	end
endmodule

// ===== design/smd_dp.sv =====
// Datapath of the SHA-1 digest unit: buffer, schedule, rounds, chaining words.
module smd_dp import smd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input dp_cmd_t cmd,
	input logic [2:0] out_idx,
	output logic [31:0] out_word,
	output dp_sts_t sts
);
	logic [31:0] buf_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [63:0] cnt_q;
	logic [5:0] pos_q;
	logic [6:0] rnd_q;
	logic [31:0] w, f, k, t, wx;
	logic [3:0] ri, bi;
	logic [1:0] sh;
	logic [31:0] mask, ins;
	logic [63:0] bits;

	assign ri = rnd_q[3:0];
	assign wx = buf_q[ri - 4'd3] ^ buf_q[ri - 4'd8] ^ buf_q[ri - 4'd14] ^ buf_q[ri];
	assign w = (rnd_q < 7'd16) ? buf_q[ri] : {wx[30:0], wx[31]};
	assign bi = pos_q[5:2];
	assign sh = pos_q[1:0];
	assign mask = ~(32'hFF000000 >> {sh, 3'b000});
	assign ins = {cmd.put_val, 24'h0} >> {sh, 3'b000};
	assign bits = {cnt_q[60:0], 3'b000};

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w;
	end

	always_ff @(posedge clk) begin
		if (cmd.put_byte) buf_q[bi] <= (buf_q[bi] & mask) | ins;
		if (cmd.put_len) begin
			buf_q[14] <= bits[63:32];
			buf_q[15] <= bits[31:0];
		end
		if (cmd.round) buf_q[ri] <= w;
		if (cmd.start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= H0_INIT;
			h_q[1] <= H1_INIT;
			h_q[2] <= H2_INIT;
			h_q[3] <= H3_INIT;
			h_q[4] <= H4_INIT;
			cnt_q <= '0;
			pos_q <= '0;
			rnd_q <= '0;
		end else begin
			if (cmd.reset_msg) begin
				h_q[0] <= H0_INIT;
				h_q[1] <= H1_INIT;
				h_q[2] <= H2_INIT;
				h_q[3] <= H3_INIT;
				h_q[4] <= H4_INIT;
				cnt_q <= '0;
				pos_q <= '0;
			end else begin
				if (cmd.finish) begin
					h_q[0] <= h_q[0] + t;
					h_q[1] <= h_q[1] + a_q;
					h_q[2] <= h_q[2] + {b_q[1:0], b_q[31:2]};
					h_q[3] <= h_q[3] + c_q;
					h_q[4] <= h_q[4] + d_q;
				end
				if (cmd.count_inc) cnt_q <= cnt_q + 64'd1;
				if (cmd.put_byte) pos_q <= pos_q + 6'd1;
				else if (cmd.start) pos_q <= 6'd0;
			end
			if (cmd.round) rnd_q <= (rnd_q == LAST_ROUND) ? 7'd0 : rnd_q + 7'd1;
		end
	end

	always_comb begin
		unique case (out_idx)
			3'd0: out_word = h_q[0];
			3'd1: out_word = h_q[1];
			3'd2: out_word = h_q[2];
			3'd3: out_word = h_q[3];
			default: out_word = h_q[4];
		endcase
	end

	assign sts.pos = pos_q;
	assign sts.last_round = rnd_q == LAST_ROUND;
endmodule

// ===== design/sha1_message_digest_unit.sv =====
// Top level of the SHA-1 message digest unit.
// Every 64th byte starts a compression of the block, and no input is taken
// until it ends. A final item adds padding bytes, the 64-bit length word,
// one or two compressions, then five digest word transfers.
// arst_n loads the initial hash values and clears count and control.
// After the fifth word the unit returns to its reset values by itself.
module sha1_message_digest_unit import smd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // data_byte
	input logic s_tuser, // has_byte
	input logic s_tlast, // last_item
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata, // digest_word
	output logic [2:0] m_tuser, // word_index
	output logic m_tlast // last_word
);
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [2:0] idx;

	smd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_tvalid && s_tready), .in_byte(s_tdata), .in_has(s_tuser),
		.in_last(s_tlast), .in_rdy(s_tready),
		.out_fire(m_tvalid && m_tready), .out_vld(m_tvalid), .out_idx(idx),
		.sts(sts), .cmd(cmd)
	);

	smd_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .out_idx(idx),
		.out_word(m_tdata), .sts(sts)
	);

	assign m_tuser = idx;
	assign m_tlast = idx == 3'd4;
endmodule

// ===== design/smd_checker.sv =====
// Port checker for the SHA-1 digest unit, with its bind.
module smd_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0] m_tuser,
	input logic m_tlast
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input taken during digest output");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= 3'd4) else $error("word index out of range");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == 3'd4))) else $error("last word flag wrong");
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == $past(m_tuser) + 3'd1)
		else $error("digest words not consecutive");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled digest word changed");
endmodule

bind sha1_message_digest_unit smd_checker u_smd_checker (.*);
